[hw/rtl/i2c_master_transaction_sequencer_top_assert.svh]
// assertion macros for the i2c transfer sequencer
// expects signals named clk and rst in the module that uses them
`ifndef I2C_MASTER_TRANSACTION_SEQUENCER_TOP_ASSERT_SVH
`define I2C_MASTER_TRANSACTION_SEQUENCER_TOP_ASSERT_SVH

// same-cycle implication
`define I2CSEQ_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define I2CSEQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/i2cseq_pkg.sv]
// shared types and codes for the i2c transfer sequencer
// no dependencies
package i2cseq_pkg;

  // address byte direction bit
  localparam logic DIR_READ  = 1'b1;
  localparam logic DIR_WRITE = 1'b0;

  // item kind
  localparam logic ACT_COMMAND = 1'b0;
  localparam logic ACT_EVENT   = 1'b1;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_START   = 3'd1,
    CMD_SEND    = 3'd2,
    CMD_RX_ACK  = 3'd3,
    CMD_RX_NACK = 3'd4,
    CMD_STOP    = 3'd5,
    CMD_KEEP    = 3'd6,
    CMD_RELEASE = 3'd7
  } bus_cmd_t;

  typedef enum logic [2:0] {
    OUT_OK         = 3'd0,
    OUT_ADDR_NACK  = 3'd1,
    OUT_DATA_NACK  = 3'd2,
    OUT_ARB_LOST   = 3'd3,
    OUT_UNEXPECTED = 3'd4
  } outcome_t;

  typedef enum logic [3:0] {
    EV_START      = 4'd0,
    EV_RSTART     = 4'd1,
    EV_AW_ACK     = 4'd2,
    EV_DS_ACK     = 4'd3,
    EV_AW_NACK    = 4'd4,
    EV_DS_NACK    = 4'd5,
    EV_AR_ACK     = 4'd6,
    EV_DR_ACK     = 4'd7,
    EV_AR_NACK    = 4'd8,
    EV_DR_NACK    = 4'd9,
    EV_ARB_LOST   = 4'd10,
    EV_OTHER      = 4'd11
  } bus_event_t;

  typedef struct packed {
    logic       action;
    logic [6:0] slave_address;
    logic       read_not_write;
    logic [7:0] transfer_length;
    logic       stop_at_end;
    logic [3:0] bus_event;
    logic [7:0] rx_byte;
    logic [7:0] tx_byte;
  } item_t;

  typedef struct packed {
    bus_cmd_t   bus_command;
    logic [7:0] tx_value;
    logic       read_valid;
    logic [7:0] read_value;
    logic       finished;
    outcome_t   outcome;
  } result_t;

  typedef struct packed {
    logic       busy;
    logic [7:0] address_byte;
    logic [7:0] bytes_left;
    logic       end_with_stop;
    logic       reading;
  } seq_state_t;

endpackage

[hw/rtl/i2cseq_in_reg.sv]
// input stage: holds one accepted item until the decision logic takes it
// depends on i2cseq_pkg
module i2cseq_in_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  i2cseq_pkg::item_t   in_item,
  input  logic                advance,
  output logic                stage_valid,
  output i2cseq_pkg::item_t   stage_item
);

  logic load;

  // free when empty or when the held item moves on this cycle
  assign in_ready = !stage_valid || advance;
  assign load     = in_valid && in_ready;

  // occupancy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (load) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      stage_item <= in_item;
    end
  end

endmodule

[hw/rtl/i2cseq_step.sv]
// transfer state and per-item decision logic
// depends on i2cseq_pkg and the assertion macro header
`include "i2c_master_transaction_sequencer_top_assert.svh"

module i2cseq_step (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  i2cseq_pkg::item_t     item,
  output i2cseq_pkg::result_t   res
);

  i2cseq_pkg::seq_state_t st;
  i2cseq_pkg::seq_state_t st_next;
  logic                   fin;
  i2cseq_pkg::outcome_t   fin_code;
  logic [7:0]             left_after;

  // count after taking a received byte, never below zero
  assign left_after = (st.bytes_left != 8'd0) ? st.bytes_left - 8'd1 : st.bytes_left;

  // decision for one item
  always_comb begin
    res         = '0;
    res.bus_command = i2cseq_pkg::CMD_NONE;
    res.outcome = i2cseq_pkg::OUT_OK;
    st_next     = st;
    fin         = 1'b0;
    fin_code    = i2cseq_pkg::OUT_OK;
    if (item.action == i2cseq_pkg::ACT_COMMAND) begin
      if (!st.busy) begin
        st_next.reading       = item.read_not_write;
        st_next.address_byte  = {item.slave_address,
                                 item.read_not_write ? i2cseq_pkg::DIR_READ
                                                     : i2cseq_pkg::DIR_WRITE};
        st_next.bytes_left    = item.transfer_length;
        st_next.end_with_stop = item.stop_at_end;
        st_next.busy          = 1'b1;
        res.bus_command       = i2cseq_pkg::CMD_START;
      end
    end else if (st.busy) begin
      case (item.bus_event)
        i2cseq_pkg::EV_START, i2cseq_pkg::EV_RSTART: begin
          res.bus_command = i2cseq_pkg::CMD_SEND;
          res.tx_value    = st.address_byte;
        end
        i2cseq_pkg::EV_AW_ACK, i2cseq_pkg::EV_DS_ACK: begin
          if (st.reading) begin
            fin      = 1'b1;
            fin_code = i2cseq_pkg::OUT_UNEXPECTED;
          end else if (st.bytes_left != 8'd0) begin
            res.bus_command    = i2cseq_pkg::CMD_SEND;
            res.tx_value       = item.tx_byte;
            st_next.bytes_left = st.bytes_left - 8'd1;
          end else begin
            fin = 1'b1;
          end
        end
        i2cseq_pkg::EV_AW_NACK: begin
          fin      = 1'b1;
          fin_code = st.reading ? i2cseq_pkg::OUT_UNEXPECTED : i2cseq_pkg::OUT_ADDR_NACK;
        end
        i2cseq_pkg::EV_DS_NACK: begin
          fin      = 1'b1;
          fin_code = st.reading ? i2cseq_pkg::OUT_UNEXPECTED : i2cseq_pkg::OUT_DATA_NACK;
        end
        i2cseq_pkg::EV_AR_ACK: begin
          if (!st.reading) begin
            fin      = 1'b1;
            fin_code = i2cseq_pkg::OUT_UNEXPECTED;
          end else begin
            res.bus_command = (st.bytes_left > 8'd1) ? i2cseq_pkg::CMD_RX_ACK
                                                     : i2cseq_pkg::CMD_RX_NACK;
          end
        end
        i2cseq_pkg::EV_DR_ACK: begin
          if (!st.reading) begin
            fin      = 1'b1;
            fin_code = i2cseq_pkg::OUT_UNEXPECTED;
          end else begin
            res.read_valid     = (st.bytes_left != 8'd0);
            res.read_value     = (st.bytes_left != 8'd0) ? item.rx_byte : 8'd0;
            st_next.bytes_left = left_after;
            // request the next byte or wrap up
            if (left_after > 8'd1) begin
              res.bus_command = i2cseq_pkg::CMD_RX_ACK;
            end else if (left_after == 8'd1) begin
              res.bus_command = i2cseq_pkg::CMD_RX_NACK;
            end else begin
              fin = 1'b1;
            end
          end
        end
        i2cseq_pkg::EV_AR_NACK: begin
          fin      = 1'b1;
          fin_code = st.reading ? i2cseq_pkg::OUT_ADDR_NACK : i2cseq_pkg::OUT_UNEXPECTED;
        end
        i2cseq_pkg::EV_DR_NACK: begin
          fin = 1'b1;
          if (!st.reading) begin
            fin_code = i2cseq_pkg::OUT_UNEXPECTED;
          end else begin
            res.read_valid     = (st.bytes_left != 8'd0);
            res.read_value     = (st.bytes_left != 8'd0) ? item.rx_byte : 8'd0;
            st_next.bytes_left = left_after;
          end
        end
        i2cseq_pkg::EV_ARB_LOST: begin
          res.bus_command = i2cseq_pkg::CMD_RELEASE;
          res.finished    = 1'b1;
          res.outcome     = i2cseq_pkg::OUT_ARB_LOST;
          st_next.busy    = 1'b0;
        end
        default: begin
          fin      = 1'b1;
          fin_code = i2cseq_pkg::OUT_UNEXPECTED;
        end
      endcase
      // common end of transfer
      if (fin) begin
        res.bus_command = st.end_with_stop ? i2cseq_pkg::CMD_STOP : i2cseq_pkg::CMD_KEEP;
        res.finished    = 1'b1;
        res.outcome     = fin_code;
        st_next.busy    = 1'b0;
      end
    end
  end

  // transfer state, updated once per item
  always_ff @(posedge clk) begin
    if (rst) begin
      st.busy          <= 1'b0;
      st.address_byte  <= 8'd0;
      st.bytes_left    <= 8'd0;
      st.end_with_stop <= 1'b1;
      st.reading       <= 1'b0;
    end else if (fire) begin
      st <= st_next;
    end
  end

  `I2CSEQ_ASSERT_NEXT(a_finish_clears_busy, fire && res.finished, !st.busy,
    "transfer still busy after it finished")
  `I2CSEQ_ASSERT_IMPLY(a_idle_event_silent,
    fire && !st.busy && item.action == i2cseq_pkg::ACT_EVENT,
    res == '0, "event while idle produced a result")
  `I2CSEQ_ASSERT_IMPLY(a_read_only_when_reading, fire && res.read_valid,
    st.busy && st.reading && st.bytes_left != 8'd0, "byte delivered outside a read")
  `I2CSEQ_ASSERT_NEXT(a_start_sets_busy, fire && res.bus_command == i2cseq_pkg::CMD_START,
    st.busy, "start issued without entering a transfer")

endmodule

[hw/rtl/i2cseq_out_reg.sv]
// result register toward the receiver
// depends on i2cseq_pkg
module i2cseq_out_reg (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  i2cseq_pkg::result_t   res,
  output logic                  can_take,
  output logic                  out_valid,
  input  logic                  out_ready,
  output i2cseq_pkg::result_t   held
);

  // room when empty or when the current beat leaves this cycle
  assign can_take = !out_valid || out_ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

endmodule

[hw/rtl/i2c_master_transaction_sequencer_top.sv]
// I2C master transfer sequencer, top level
// Input channel (in_valid/in_ready) carries either a transfer command
// (action 0: address, direction, length, stop flag) or a bus status event
// (action 1: event code plus received or next write byte).
// Output channel (out_valid/out_ready) returns exactly one beat per input
// beat: the next bus command, the byte to send, an optional received byte,
// and on the last beat of a transfer the finished flag and outcome code.
// Path: an accepted item is registered in the input register, passes the
// decision logic and is registered again in the result register, which
// drives out_valid. Throughput: one beat per cycle while the receiver
// keeps out_ready high.
// Reset clears both stage valid flags and returns the transfer state to
// idle with stop-at-end set; events before the next command return all-zero
// beats.
// When the receiver stalls the result register holds its beat, the input
// register keeps at most one more, and in_ready drops after that.
// Depends on i2cseq_pkg, i2cseq_in_reg, i2cseq_step, i2cseq_out_reg.
module i2c_master_transaction_sequencer_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       action,
  input  logic [6:0] slave_address,
  input  logic       read_not_write,
  input  logic [7:0] transfer_length,
  input  logic       stop_at_end,
  input  logic [3:0] bus_event,
  input  logic [7:0] rx_byte,
  input  logic [7:0] tx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] bus_command,
  output logic [7:0] tx_value,
  output logic       read_valid,
  output logic [7:0] read_value,
  output logic       finished,
  output logic [2:0] outcome
);

  i2cseq_pkg::item_t   in_item;
  i2cseq_pkg::item_t   stage_item;
  i2cseq_pkg::result_t step_res;
  i2cseq_pkg::result_t held;
  logic                stage_valid;
  logic                can_take;
  logic                advance;

  // pack input fields
  assign in_item = '{action: action, slave_address: slave_address,
                     read_not_write: read_not_write, transfer_length: transfer_length,
                     stop_at_end: stop_at_end, bus_event: bus_event,
                     rx_byte: rx_byte, tx_byte: tx_byte};

  // item moves from input stage to result register
  assign advance = stage_valid && can_take;

  i2cseq_in_reg u_in_reg (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  i2cseq_step u_step (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .item (stage_item),
    .res  (step_res)
  );

  i2cseq_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .res       (step_res),
    .can_take  (can_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .held      (held)
  );

  // unpack result fields
  assign bus_command = held.bus_command;
  assign tx_value    = held.tx_value;
  assign read_valid  = held.read_valid;
  assign read_value  = held.read_value;
  assign finished    = held.finished;
  assign outcome     = held.outcome;

endmodule
